### hw/rtl/cils_pkg.sv
`timescale 1ns / 1ps

package cils_pkg;

   // Literal kinds reported on the result channel
   localparam logic [2:0] KIND_INT       = 3'd0;
   localparam logic [2:0] KIND_UINT      = 3'd1;
   localparam logic [2:0] KIND_LONG      = 3'd2;
   localparam logic [2:0] KIND_ULONG     = 3'd3;
   localparam logic [2:0] KIND_LLONG     = 3'd4;
   localparam logic [2:0] KIND_ULLONG    = 3'd5;
   localparam logic [2:0] KIND_FLOAT     = 3'd6;

   // Number base of the literal being scanned
   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_OCT = 2'd1,
      BASE_HEX = 2'd2
   } base_type;

   // Character codes
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_UPPER_U = 8'h55;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_UPPER_L = 8'h4C;
   localparam logic [7:0] CH_LOWER_L = 8'h6C;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LOWER_E = 8'h65;

   // Value of the first hex letter
   localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

endpackage

### hw/rtl/c_integer_literal_scanner.sv
`timescale 1ns / 1ps

// C integer literal scanner.
// The req channel carries one source byte per beat (req_char_byte), or an
// end-of-text marker (req_end_of_text) that flushes a pending literal. The
// rsp channel carries one beat per finished literal: its kind, the low 32
// bits of its value, an overflow flag and a missing-hex-digit flag.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. The block takes one byte per cycle while req_stall is low: a
// beat goes into an input register, the scanner state and any result are
// worked out combinationally from that register, and a result lands in
// the rsp output register. A finished literal thus passes the input
// register and then the result register before it is presented on rsp.
// The result register holds while rsp_stall is high; a byte that would
// produce a result then waits in the input register, and req_stall rises.
// Bytes that produce no result still pass while a result is held.
// Reset (synchronous) empties both registers and returns the scanner to
// idle with a cleared literal.
module c_integer_literal_scanner
   import cils_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_literal_kind,
   output logic [31:0] rsp_literal_value,
   output logic        rsp_too_big,
   output logic        rsp_hex_digit_missing
);

   localparam int ExtBits = VALUE_BITS + 4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ZERO,
      PH_HEXPFX,
      PH_DIGITS,
      PH_AFTERU,
      PH_AFTERL
   } phase_type;

   // Input register
   logic                  in_valid_ff;
   logic [7:0]            char_ff;
   logic                  eot_ff;

   // Scanner state
   phase_type             phase_ff, phase_in;
   base_type              base_ff, base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic [2:0]            suffix_ff, suffix_in;

   // Result register
   logic                  rsp_valid_ff;
   logic [2:0]            kind_ff, kind_in;
   logic [31:0]           value_ff, value_in;
   logic                  big_ff, big_in;
   logic                  miss_ff, miss_in;

   logic                  proc_go;
   logic                  emit;
   logic                  req_take;
   logic                  rsp_take;

   // Character classes
   logic                  is_dec, is_lo_hex, is_up_hex, is_u, is_l, is_float_mark;
   logic                  is_x, is_zero, is_nonzero;
   logic [3:0]            any_val;
   logic                  any_digit;

   // Digit check in the current base and in hex
   logic                  digit_ok, hex_ok;
   logic [3:0]            digit_val;

   // Accumulate datapath
   base_type              acc_base;
   logic [ExtBits-1:0]    acc_ext, acc_prod, acc_sum;

   // Idle re-examination of the byte
   phase_type             idle_phase;
   base_type              idle_base;
   logic [VALUE_BITS-1:0] idle_acc;

   // Handshake
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign proc_go   = in_valid_ff && (!emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proc_go;
   assign req_take  = req_valid && !req_stall;

   // Classify the byte
   always_comb begin
      is_dec        = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
      is_lo_hex     = (char_ff >= CH_LOWER_A) && (char_ff <= CH_LOWER_F);
      is_up_hex     = (char_ff >= CH_UPPER_A) && (char_ff <= CH_UPPER_F);
      is_u          = (char_ff == CH_UPPER_U) || (char_ff == CH_LOWER_U);
      is_l          = (char_ff == CH_UPPER_L) || (char_ff == CH_LOWER_L);
      is_x          = (char_ff == CH_UPPER_X) || (char_ff == CH_LOWER_X);
      is_float_mark = (char_ff == CH_DOT) || (char_ff == CH_LOWER_E)
                      || (char_ff == CH_UPPER_E);
      is_zero       = (char_ff == CH_ZERO);
      is_nonzero    = (char_ff >= CH_ONE) && (char_ff <= CH_NINE);
      any_digit     = is_dec || is_lo_hex || is_up_hex;
      if (is_dec) begin
         any_val = 4'(char_ff - CH_ZERO);
      end else if (is_lo_hex) begin
         any_val = 4'(char_ff - CH_LOWER_A + HEX_LETTER_BASE);
      end else begin
         any_val = 4'(char_ff - CH_UPPER_A + HEX_LETTER_BASE);
      end
      digit_val = any_val;
      hex_ok    = any_digit;
      case (base_ff)
         BASE_HEX: digit_ok = any_digit;
         BASE_OCT: digit_ok = is_dec && !any_val[3];
         default:  digit_ok = is_dec;
      endcase
   end

   // Multiply by the radix with shifts and add the digit
   always_comb begin
      acc_base = (phase_ff == PH_HEXPFX) ? BASE_HEX : base_ff;
      acc_ext  = {4'b0000, acc_ff};
      case (acc_base)
         BASE_HEX: acc_prod = acc_ext << 4;
         BASE_OCT: acc_prod = acc_ext << 3;
         default:  acc_prod = (acc_ext << 3) + (acc_ext << 1);
      endcase
      acc_sum = acc_prod + ExtBits'(digit_val);
   end

   // Start of a literal from the idle phase
   always_comb begin
      idle_phase = PH_IDLE;
      idle_base  = BASE_DEC;
      idle_acc   = '0;
      if (is_zero) begin
         idle_phase = PH_ZERO;
         idle_base  = BASE_OCT;
      end else if (is_nonzero) begin
         idle_phase = PH_DIGITS;
         idle_acc   = VALUE_BITS'(any_val);
      end
   end

   // Next state and result
   always_comb begin
      phase_in  = phase_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      suffix_in = suffix_ff;
      emit      = 1'b0;
      kind_in   = suffix_ff;
      value_in  = 32'(acc_ff);
      big_in    = ovf_ff;
      miss_in   = 1'b0;
      // pending literal: "0x" alone gives the missing-digit result
      if (phase_ff == PH_HEXPFX) begin
         kind_in  = KIND_INT;
         value_in = '0;
         big_in   = 1'b0;
         miss_in  = 1'b1;
      end

      if (eot_ff) begin
         emit      = (phase_ff != PH_IDLE);
         phase_in  = PH_IDLE;
         base_in   = BASE_DEC;
         acc_in    = '0;
         ovf_in    = 1'b0;
         suffix_in = KIND_INT;
      end else begin
         // assume the literal ends here; the arms below override
         emit      = (phase_ff != PH_IDLE);
         phase_in  = idle_phase;
         base_in   = idle_base;
         acc_in    = idle_acc;
         ovf_in    = 1'b0;
         suffix_in = KIND_INT;
         unique case (phase_ff)
            PH_IDLE: begin
               emit = 1'b0;
            end
            PH_HEXPFX: begin
               if (hex_ok) begin
                  emit      = 1'b0;
                  phase_in  = PH_DIGITS;
                  base_in   = base_ff;
                  acc_in    = acc_sum[VALUE_BITS-1:0];
                  ovf_in    = ovf_ff || (|acc_sum[ExtBits-1:VALUE_BITS]);
                  suffix_in = suffix_ff;
               end
            end
            PH_ZERO, PH_DIGITS: begin
               if (phase_ff == PH_ZERO && is_x) begin
                  emit      = 1'b0;
                  phase_in  = PH_HEXPFX;
                  base_in   = BASE_HEX;
                  acc_in    = acc_ff;
                  ovf_in    = ovf_ff;
                  suffix_in = suffix_ff;
               end else if (digit_ok) begin
                  emit      = 1'b0;
                  phase_in  = PH_DIGITS;
                  base_in   = base_ff;
                  acc_in    = acc_sum[VALUE_BITS-1:0];
                  ovf_in    = ovf_ff || (|acc_sum[ExtBits-1:VALUE_BITS]);
                  suffix_in = suffix_ff;
               end else if (base_ff != BASE_HEX && is_float_mark) begin
                  // hand off to float scanning: consume the byte
                  phase_in = PH_IDLE;
                  base_in  = BASE_DEC;
                  acc_in   = '0;
                  kind_in  = KIND_FLOAT;
                  value_in = '0;
                  big_in   = 1'b0;
               end else if (is_u) begin
                  emit      = 1'b0;
                  phase_in  = PH_AFTERU;
                  base_in   = base_ff;
                  acc_in    = acc_ff;
                  ovf_in    = ovf_ff;
                  suffix_in = KIND_UINT;
               end else if (is_l) begin
                  emit      = 1'b0;
                  phase_in  = PH_AFTERL;
                  base_in   = base_ff;
                  acc_in    = acc_ff;
                  ovf_in    = ovf_ff;
                  suffix_in = KIND_LONG;
               end
            end
            PH_AFTERU: begin
               if (is_l) begin
                  emit      = 1'b0;
                  phase_in  = PH_AFTERL;
                  base_in   = base_ff;
                  acc_in    = acc_ff;
                  ovf_in    = ovf_ff;
                  suffix_in = KIND_ULONG;
               end
            end
            PH_AFTERL: begin
               if (is_l) begin
                  // second L completes the literal; byte is consumed
                  phase_in = PH_IDLE;
                  base_in  = BASE_DEC;
                  acc_in   = '0;
                  kind_in  = (suffix_ff == KIND_ULONG) ? KIND_ULLONG : KIND_LLONG;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   // Registers: input stage, scanner state, result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         base_ff      <= BASE_DEC;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         suffix_ff    <= KIND_INT;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (proc_go) begin
            in_valid_ff <= 1'b0;
         end
         if (proc_go) begin
            phase_ff  <= phase_in;
            base_ff   <= base_in;
            acc_ff    <= acc_in;
            ovf_ff    <= ovf_in;
            suffix_ff <= suffix_in;
         end
         if (proc_go && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // payload: no reset needed
      if (req_take) begin
         char_ff <= req_char_byte;
         eot_ff  <= req_end_of_text;
      end
      if (proc_go && emit) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         big_ff   <= big_in;
         miss_ff  <= miss_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_literal_kind      = kind_ff;
   assign rsp_literal_value     = value_ff;
   assign rsp_too_big           = big_ff;
   assign rsp_hex_digit_missing = miss_ff;

   // Checks
   a_float_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_literal_kind == KIND_FLOAT
      |-> rsp_literal_value == '0 && !rsp_too_big && !rsp_hex_digit_missing)
      else $error("float handoff carries a value or flag");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hex_digit_missing
      |-> rsp_literal_kind == KIND_INT && rsp_literal_value == '0 && !rsp_too_big)
      else $error("missing hex digit result is not a plain zero");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      proc_go && emit |=> rsp_valid)
      else $error("finished literal not presented");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with a free stage");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> acc_ff == '0 && !ovf_ff && suffix_ff == KIND_INT)
      else $error("idle scanner holds literal state");

endmodule

### tb/c_integer_literal_scanner_checker.sv
`timescale 1ns / 1ps

module c_integer_literal_scanner_checker
   import cils_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_literal_kind,
   input  logic [31:0] rsp_literal_value,
   input  logic        rsp_too_big,
   input  logic        rsp_hex_digit_missing,
   output int          fail_count,
   output int          literals_checked,
   output int          literals_outstanding
);

   localparam int unsigned NO_DIGIT = 16;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_ZERO,
      SCAN_HEX_PREFIX,
      SCAN_DIGITS,
      SCAN_SUFFIX_U,
      SCAN_SUFFIX_L
   } scan_phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic        too_big;
      logic        hex_missing;
   } literal_type;

   // Own copy of the scanner state
   scan_phase_type phase;
   base_type       base;
   logic [31:0]    accum;
   logic           overflowed;
   logic [2:0]     suffix;

   literal_type expected_literals[$];
   int          errors = 0;
   int          checked = 0;

   assign fail_count       = errors;
   assign literals_checked = checked;

   function automatic int unsigned radix_of(base_type b);
      return (b == BASE_HEX) ? 16 : ((b == BASE_OCT) ? 8 : 10);
   endfunction

   function automatic int unsigned digit_value(logic [7:0] c, base_type b);
      int unsigned d;
      d = NO_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE)
         d = 32'(c - CH_ZERO);
      else if (b == BASE_HEX && c >= CH_LOWER_A && c <= CH_LOWER_F)
         d = 32'(c - CH_LOWER_A + HEX_LETTER_BASE);
      else if (b == BASE_HEX && c >= CH_UPPER_A && c <= CH_UPPER_F)
         d = 32'(c - CH_UPPER_A + HEX_LETTER_BASE);
      if (d >= radix_of(b))
         d = NO_DIGIT;
      return d;
   endfunction

   function automatic bit is_u(logic [7:0] c);
      return c == CH_UPPER_U || c == CH_LOWER_U;
   endfunction

   function automatic bit is_l(logic [7:0] c);
      return c == CH_UPPER_L || c == CH_LOWER_L;
   endfunction

   task automatic clear_literal();
      phase      = SCAN_IDLE;
      base       = BASE_DEC;
      accum      = '0;
      overflowed = 1'b0;
      suffix     = KIND_INT;
   endtask

   task automatic push_literal(logic [2:0] kind, logic [31:0] value, logic big, logic miss);
      literal_type lit;
      lit.kind        = kind;
      lit.value       = value;
      lit.too_big     = big;
      lit.hex_missing = miss;
      expected_literals.push_back(lit);
   endtask

   // Emit whatever literal is in progress, then go idle
   task automatic flush_pending();
      if (phase == SCAN_HEX_PREFIX)
         push_literal(KIND_INT, '0, 1'b0, 1'b1);
      else
         push_literal(suffix, accum, overflowed, 1'b0);
      clear_literal();
   endtask

   // Idle: a digit opens a literal, anything else is skipped
   task automatic start_from_idle(logic [7:0] c);
      if (c == CH_ZERO) begin
         clear_literal();
         phase = SCAN_ZERO;
         base  = BASE_OCT;
      end else if (c >= CH_ONE && c <= CH_NINE) begin
         clear_literal();
         phase = SCAN_DIGITS;
         accum = 32'(c - CH_ZERO);
      end
   endtask

   // value*base+digit, with a sticky flag once the true value leaves 32 bits
   task automatic take_digit(int unsigned d);
      logic [63:0] wide;
      wide = {32'd0, accum} * 64'(radix_of(base)) + 64'(d);
      if (wide > 64'h0000_0000_FFFF_FFFF)
         overflowed = 1'b1;
      accum = wide[31:0];
   endtask

   task automatic lex_byte(logic [7:0] c, logic eot);
      int unsigned d;
      if (eot) begin
         if (phase != SCAN_IDLE)
            flush_pending();
         return;
      end
      case (phase)
         SCAN_HEX_PREFIX: begin
            d = digit_value(c, BASE_HEX);
            if (d != NO_DIGIT) begin
               take_digit(d);
               phase = SCAN_DIGITS;
               return;
            end
         end
         SCAN_ZERO, SCAN_DIGITS: begin
            if (phase == SCAN_ZERO && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
               phase = SCAN_HEX_PREFIX;
               base  = BASE_HEX;
               return;
            end
            d = digit_value(c, base);
            if (d != NO_DIGIT) begin
               take_digit(d);
               phase = SCAN_DIGITS;
               return;
            end
            if (base != BASE_HEX && (c == CH_DOT || c == CH_LOWER_E || c == CH_UPPER_E)) begin
               push_literal(KIND_FLOAT, '0, 1'b0, 1'b0);
               clear_literal();
               return;
            end
            if (is_u(c)) begin
               suffix = KIND_UINT;
               phase  = SCAN_SUFFIX_U;
               return;
            end
            if (is_l(c)) begin
               suffix = KIND_LONG;
               phase  = SCAN_SUFFIX_L;
               return;
            end
         end
         SCAN_SUFFIX_U: begin
            if (is_l(c)) begin
               suffix = KIND_ULONG;
               phase  = SCAN_SUFFIX_L;
               return;
            end
         end
         SCAN_SUFFIX_L: begin
            // second L closes the literal on this beat
            if (is_l(c)) begin
               suffix = (suffix == KIND_ULONG) ? KIND_ULLONG : KIND_LLONG;
               flush_pending();
               return;
            end
         end
         default: begin
            start_from_idle(c);
            return;
         end
      endcase
      // byte is not part of the literal: close it and look at the byte again
      flush_pending();
      start_from_idle(c);
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Compare result beats first, then advance the model on the request beat
   always @(posedge clock) begin
      literal_type want;
      if (reset) begin
         clear_literal();
         expected_literals.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_literals.size() == 0) begin
               $display("%0t: unexpected result beat, actual kind %0d value %0h",
                        $time, rsp_literal_kind, rsp_literal_value);
               errors++;
            end else begin
               want = expected_literals.pop_front();
               report_field("literal_kind", 32'(want.kind), 32'(rsp_literal_kind));
               report_field("literal_value", want.value, rsp_literal_value);
               report_field("too_big", 32'(want.too_big), 32'(rsp_too_big));
               report_field("hex_digit_missing", 32'(want.hex_missing),
                            32'(rsp_hex_digit_missing));
               checked++;
            end
         end
         if (req_valid && !req_stall)
            lex_byte(req_char_byte, req_end_of_text);
      end
      literals_outstanding <= expected_literals.size();
   end

endmodule

### tb/tb_c_integer_literal_scanner.sv
`timescale 1ns / 1ps

module tb_c_integer_literal_scanner
   import cils_pkg::*;
();

   localparam int        RANDOM_BEATS = 800;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_SEMI     = 8'h3B;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_literal_kind;
   logic [31:0] rsp_literal_value;
   logic        rsp_too_big;
   logic        rsp_hex_digit_missing;

   int fail_count;
   int literals_checked;
   int literals_outstanding;
   int beats_sent = 0;
   int markers_sent = 0;
   bit calm = 1'b0;

   always #5 clock = ~clock;

   c_integer_literal_scanner u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_char_byte         (req_char_byte),
      .req_end_of_text       (req_end_of_text),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_literal_kind      (rsp_literal_kind),
      .rsp_literal_value     (rsp_literal_value),
      .rsp_too_big           (rsp_too_big),
      .rsp_hex_digit_missing (rsp_hex_digit_missing)
   );

   c_integer_literal_scanner_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_char_byte         (req_char_byte),
      .req_end_of_text       (req_end_of_text),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_literal_kind      (rsp_literal_kind),
      .rsp_literal_value     (rsp_literal_value),
      .rsp_too_big           (rsp_too_big),
      .rsp_hex_digit_missing (rsp_hex_digit_missing),
      .fail_count            (fail_count),
      .literals_checked      (literals_checked),
      .literals_outstanding  (literals_outstanding)
   );

   // Random back-pressure on the result side, off while calm
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 20);

   // Move one beat, with an occasional idle gap in front of it
   task automatic put_beat(logic [7:0] c, logic eot);
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (eot)
         markers_sent++;
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++)
         put_beat(s[i], 1'b0);
   endtask

   task automatic put_marker();
      put_beat(8'($urandom_range(255)), 1'b1);
   endtask

   // Hold the sender until every expected literal has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (literals_outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_u();
      return $urandom_range(1) ? CH_UPPER_U : CH_LOWER_U;
   endfunction

   function automatic logic [7:0] pick_l();
      return $urandom_range(1) ? CH_UPPER_L : CH_LOWER_L;
   endfunction

   // One literal with random digits, a random (at times out-of-order)
   // suffix and a terminator, or a single noise byte
   task automatic put_random_literal();
      string hex_chars;
      int    shape;
      int    n;
      bit    hex;
      hex_chars = "0123456789abcdefABCDEF";
      shape = $urandom_range(9);
      n = ($urandom_range(7) == 0) ? $urandom_range(14, 9) : $urandom_range(4);
      hex = 1'b0;
      if (shape == 9) begin
         put_beat(8'($urandom_range(255)), 1'b0);
         return;
      end
      if (shape <= 3) begin
         put_beat(CH_ONE + 8'($urandom_range(8)), 1'b0);
         repeat (n) put_beat(CH_ZERO + 8'($urandom_range(9)), 1'b0);
      end else if (shape <= 5) begin
         put_beat(CH_ZERO, 1'b0);
         repeat (n) put_beat(CH_ZERO + 8'($urandom_range(7)), 1'b0);
      end else begin
         hex = 1'b1;
         put_beat(CH_ZERO, 1'b0);
         put_beat($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
         if ($urandom_range(9) != 0)
            n++;
         repeat (n) put_beat(hex_chars[$urandom_range(21)], 1'b0);
      end
      case ($urandom_range(15))
         6:  put_beat(pick_u(), 1'b0);
         7:  put_beat(pick_l(), 1'b0);
         8:  begin put_beat(pick_u(), 1'b0); put_beat(pick_l(), 1'b0); end
         9:  begin put_beat(pick_l(), 1'b0); put_beat(pick_l(), 1'b0); end
         10: begin
            put_beat(pick_u(), 1'b0);
            put_beat(pick_l(), 1'b0);
            put_beat(pick_l(), 1'b0);
         end
         // suffixes out of order
         11: begin put_beat(pick_l(), 1'b0); put_beat(pick_u(), 1'b0); end
         12: begin put_beat(pick_u(), 1'b0); put_beat(pick_u(), 1'b0); end
         13: begin
            if (!hex) begin
               case ($urandom_range(2))
                  0:       put_beat(CH_DOT, 1'b0);
                  1:       put_beat(CH_LOWER_E, 1'b0);
                  default: put_beat(CH_UPPER_E, 1'b0);
               endcase
            end
         end
         14: repeat (3) put_beat(pick_l(), 1'b0);
         default: ;
      endcase
      case ($urandom_range(9))
         0:       ;
         1:       put_marker();
         2:       put_beat(8'($urandom_range(255)), 1'b0);
         3:       put_beat(CH_COMMA, 1'b0);
         4:       put_beat(CH_SEMI, 1'b0);
         default: put_beat(CH_SPACE, 1'b0);
      endcase
   endtask

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes, missing hex digit, ULL, lone zero, octal
      // broken by 8, floats, bad suffix order, end-of-text flushes
      put_beat(8'h00, 1'b0);
      put_beat(8'hFF, 1'b0);
      put_text("0xg");
      put_text("0XAuLl");
      put_text("08.");
      put_text("9lu");
      put_text("5E");
      put_text("7");
      put_marker();
      put_marker();
      put_text("0x");
      put_marker();
      drain();

      // Random: noisy, then a calm stretch, then noisy again
      while (beats_sent < RANDOM_BEATS) begin
         calm = (beats_sent >= 300 && beats_sent < 450);
         if (!paused && beats_sent >= 550) begin
            drain();
            paused = 1'b1;
         end
         put_random_literal();
      end
      put_marker();

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d source beats including %0d end-of-text markers; %0d literals checked.",
               beats_sent, markers_sent, literals_checked);
      $display("Covered all bases, suffixes, float handoffs, overflow and idle/stall mixes.");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d literals outstanding", literals_outstanding);
      $display("== FAIL ==");
      $finish;
   end

endmodule
